[design/pid_position_delta_defines.svh]
// Assertion helpers shared by the controller RTL.
// Both macros sample on the rising clock edge and are disabled while reset is high.
`ifndef PID_POSITION_DELTA_DEFINES_SVH
`define PID_POSITION_DELTA_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIDPD_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pidpd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PIDPD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pidpd: next-cycle check failed");

`endif

[design/pidpd_pkg.sv]
package pidpd_pkg;

   // Fixed widths of the register file and of the Q16.16 terms.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 31;
   localparam int GAIN_W     = 24;
   localparam int TERM_W     = 32;
   localparam int LIMIT_W    = 31;

   localparam logic signed [63:0] TERM_MAX = 64'sd2147483647;
   localparam logic signed [63:0] TERM_MIN = -64'sd2147483648;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LOOP_MODE      = 3'd0,
      CSR_GAIN_P         = 3'd1,
      CSR_GAIN_I         = 3'd2,
      CSR_GAIN_D         = 3'd3,
      CSR_OUT_LIMIT      = 3'd4,
      CSR_INTEGRAL_LIMIT = 3'd5
   } csr_index_type;

   typedef enum logic {
      MODE_POSITIONAL  = 1'b0,
      MODE_INCREMENTAL = 1'b1
   } loop_mode_type;

   typedef struct packed {
      loop_mode_type              loop_mode;
      logic signed [GAIN_W-1:0]   gain_p;
      logic signed [GAIN_W-1:0]   gain_i;
      logic signed [GAIN_W-1:0]   gain_d;
      logic        [LIMIT_W-1:0]  out_limit;
      logic        [LIMIT_W-1:0]  integral_limit;
   } pidpd_cfg_type;

   // Saturate a wide signed value to the signed 32-bit term range.
   function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [63:0] x);
      logic signed [TERM_W-1:0] r;
      if (x > TERM_MAX) begin
         r = TERM_MAX[TERM_W-1:0];
      end else if (x < TERM_MIN) begin
         r = TERM_MIN[TERM_W-1:0];
      end else begin
         r = x[TERM_W-1:0];
      end
      return r;
   endfunction

   // Clamp a signed value to plus or minus an unsigned magnitude limit.
   function automatic logic signed [TERM_W-1:0] clamp_mag(input logic signed [63:0] x,
                                                          input logic [LIMIT_W-1:0] lim);
      logic signed [63:0]       lim_s;
      logic signed [TERM_W-1:0] r;
      lim_s = $signed(64'(lim));
      if (x > lim_s) begin
         r = lim_s[TERM_W-1:0];
      end else if (x < -lim_s) begin
         r = 32'(-lim_s);
      end else begin
         r = x[TERM_W-1:0];
      end
      return r;
   endfunction

endpackage

[design/pidpd_csr.sv]
module pidpd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pidpd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [pidpd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output pidpd_pkg::pidpd_cfg_type            cfg,
   output logic                                cfg_clear
);
   import pidpd_pkg::*;

   pidpd_cfg_type cfg_ff;
   pidpd_cfg_type cfg_in;

   // Decode a write; any known register also clears the loop state.
   always_comb begin
      cfg_in    = cfg_ff;
      cfg_clear = 1'b0;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_LOOP_MODE: begin
               cfg_in.loop_mode = loop_mode_type'(csr_wdata[0]);
               cfg_clear        = 1'b1;
            end
            CSR_GAIN_P: begin
               cfg_in.gain_p = $signed(csr_wdata[GAIN_W-1:0]);
               cfg_clear     = 1'b1;
            end
            CSR_GAIN_I: begin
               cfg_in.gain_i = $signed(csr_wdata[GAIN_W-1:0]);
               cfg_clear     = 1'b1;
            end
            CSR_GAIN_D: begin
               cfg_in.gain_d = $signed(csr_wdata[GAIN_W-1:0]);
               cfg_clear     = 1'b1;
            end
            CSR_OUT_LIMIT: begin
               cfg_in.out_limit = csr_wdata[LIMIT_W-1:0];
               cfg_clear        = 1'b1;
            end
            CSR_INTEGRAL_LIMIT: begin
               cfg_in.integral_limit = csr_wdata[LIMIT_W-1:0];
               cfg_clear             = 1'b1;
            end
            default: begin
               cfg_clear = 1'b0;
            end
         endcase
      end
   end

   // Configuration registers, all zero after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/pidpd_core.sv]
`include "pid_position_delta_defines.svh"

module pidpd_core #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pidpd_pkg::pidpd_cfg_type              cfg,
   input  logic                                  cfg_clear,
   input  logic                                  step,
   input  logic signed [SAMPLE_WIDTH-1:0]        measured,
   input  logic signed [SAMPLE_WIDTH-1:0]        target,
   output logic signed [pidpd_pkg::TERM_W-1:0]   drive
);
   import pidpd_pkg::*;

   localparam int ERR_W  = SAMPLE_WIDTH + 1;
   localparam int DIFF_W = SAMPLE_WIDTH + 2;
   localparam int DD_W   = SAMPLE_WIDTH + 3;
   localparam int PROD_W = GAIN_W + DD_W;
   localparam int SUM_W  = TERM_W + 2;

   logic signed [ERR_W-1:0]  err_now_ff, err_prev_ff, err_prev2_ff;
   logic signed [TERM_W-1:0] integral_ff, last_drive_ff;
   logic signed [TERM_W-1:0] integral_in;

   logic signed [ERR_W-1:0]  err0;
   logic signed [DIFF_W-1:0] diff1;
   logic signed [DD_W-1:0]   diff2;
   logic signed [DD_W-1:0]   op_p, op_d;
   logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;
   logic signed [TERM_W-1:0] p_sat, i_sat, d_sat;
   logic signed [TERM_W-1:0] integ_sum, integ_pos;
   logic signed [SUM_W-1:0]  base, total;
   logic                     incremental;

   assign incremental = (cfg.loop_mode == MODE_INCREMENTAL);

   // Error, first difference and second difference of the error history.
   assign err0  = ERR_W'(target) - ERR_W'(measured);
   assign diff1 = DIFF_W'(err0) - DIFF_W'(err_now_ff);
   assign diff2 = DD_W'(err0) - (DD_W'(err_now_ff) <<< 1) + DD_W'(err_prev_ff);

   // The P and D multipliers take the difference that the selected form needs.
   assign op_p = incremental ? DD_W'(diff1) : DD_W'(err0);
   assign op_d = incremental ? diff2 : DD_W'(diff1);

   assign prod_p = PROD_W'($signed(cfg.gain_p)) * PROD_W'(op_p);
   assign prod_i = PROD_W'($signed(cfg.gain_i)) * PROD_W'(err0);
   assign prod_d = PROD_W'($signed(cfg.gain_d)) * PROD_W'(op_d);

   assign p_sat = sat_term(64'(prod_p));
   assign i_sat = sat_term(64'(prod_i));
   assign d_sat = sat_term(64'(prod_d));

   // Positional integral: saturating accumulate, then magnitude clamp.
   assign integ_sum = sat_term(64'(integral_ff) + 64'(i_sat));
   assign integ_pos = clamp_mag(64'(integ_sum), cfg.integral_limit);

   assign integral_in = incremental ? i_sat : integ_pos;

   // Sum of the terms and the output clamp.
   assign base  = incremental ? (SUM_W'(last_drive_ff) + SUM_W'(i_sat)) : SUM_W'(integ_pos);
   assign total = base + SUM_W'(p_sat) + SUM_W'(d_sat);
   assign drive = clamp_mag(64'(total), cfg.out_limit);

   // Loop state; a write to a known register clears it as reset does.
   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         err_now_ff    <= '0;
         err_prev_ff   <= '0;
         err_prev2_ff  <= '0;
         integral_ff   <= '0;
         last_drive_ff <= '0;
      end else if (step) begin
         err_prev2_ff  <= err_prev_ff;
         err_prev_ff   <= err_now_ff;
         err_now_ff    <= err0;
         integral_ff   <= integral_in;
         last_drive_ff <= drive;
      end
   end

   `PIDPD_ASSERT_NEXT(a_clear_zeroes_state, cfg_clear, (integral_ff == '0) && (last_drive_ff == '0) && (err_now_ff == '0) && (err_prev_ff == '0) && (err_prev2_ff == '0))

endmodule

[design/pid_position_delta.sv]
// PID controller, positional or incremental form, one sample per beat.
// The req_ channel carries one beat per control sample: measured and target.
// The rsp_ channel returns one beat per sample: the clamped drive, Q16.16.
// The csr_ port writes one register per cycle with csr_we; any write to a known
// register clears the error history, the integral and the last drive. Write
// only while the block holds no sample and no undelivered result.
// A request beat is captured in the input register; then the error, three
// multipliers, saturation and clamping run in one pass into the result
// register. Throughput is one beat per cycle while rsp_tready stays high.
// The loop state is updated in the same pass, so each sample sees the state
// left by the one before it.
// While the receiver stalls, the result is held and the input register can
// still take one more beat; req_tready falls only when both are full.
// Reset clears the configuration to zero, the loop state and both valid flags.
`include "pid_position_delta_defines.svh"

module pid_position_delta #(
   parameter  int SAMPLE_WIDTH = 16,
   localparam int REQ_W        = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [REQ_W-1:0]                     req_tdata,   // measured, target
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pidpd_pkg::TERM_W-1:0]         rsp_tdata,   // drive
   input  logic                                 csr_we,
   input  logic [pidpd_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [pidpd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pidpd_pkg::*;

   pidpd_cfg_type cfg;
   logic          cfg_clear;

   logic                           s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] s1_meas_ff, s1_targ_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [TERM_W-1:0]       rsp_drive_ff;
   logic signed [TERM_W-1:0]       drive;
   logic                           req_fire, out_free, step;

   pidpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .cfg_clear (cfg_clear)
   );

   pidpd_core #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cfg_clear (cfg_clear),
      .step      (step),
      .measured  (s1_meas_ff),
      .target    (s1_targ_ff),
      .drive     (drive)
   );

   // Handshake: the result register frees when empty or being taken.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input sample register.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_meas_ff <= $signed(req_tdata[SAMPLE_WIDTH-1:0]);
         s1_targ_ff <= $signed(req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_drive_ff <= drive;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_drive_ff;

   `PIDPD_ASSERT_IMPL(a_ready_low_only_when_full, !req_tready, s1_valid_ff && rsp_valid_ff && !rsp_tready)
   `PIDPD_ASSERT_IMPL(a_drive_within_limit, step, (drive <= $signed(32'(cfg.out_limit))) && (drive >= -$signed(32'(cfg.out_limit))))
   `PIDPD_ASSERT_IMPL(a_result_from_sample, $rose(rsp_valid_ff), $past(s1_valid_ff))

endmodule

[bench/tb_pid_position_delta.sv]
module tb_pid_position_delta;
   import pidpd_pkg::*;

   localparam int SAMPLE_W        = 16;
   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 7;
   localparam int QUIET_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int SETTLE_CYCLES   = 4;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 133;

   // Indexes beyond the register file; writes there must leave everything alone.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   // Gains in Q8.16 and limits in Q16.16 used by the directed settings.
   localparam logic [GAIN_W-1:0]  GAIN_ONE     = 24'd65536;
   localparam logic [GAIN_W-1:0]  GAIN_HALF    = 24'd32768;
   localparam logic [GAIN_W-1:0]  GAIN_QUARTER = 24'd16384;
   localparam logic [GAIN_W-1:0]  GAIN_TWO     = 24'd131072;
   localparam logic [GAIN_W-1:0]  GAIN_TOP     = 24'h7FFFFF;
   localparam logic [GAIN_W-1:0]  GAIN_BOTTOM  = 24'h800000;
   localparam logic [LIMIT_W-1:0] LIMIT_TOP    = 31'h7FFFFFFF;

   // One request beat: target in the upper half, measured in the lower half.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] target;
      logic signed [SAMPLE_W-1:0] measured;
   } sample_pair_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata  = '0;   // measured, target
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TERM_W-1:0]     rsp_tdata;         // drive
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   pid_position_delta #(.SAMPLE_WIDTH(SAMPLE_W)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Shadow copy of the controller: configuration and loop state.
   loop_mode_type ctl_mode = MODE_POSITIONAL;
   longint kp = 0, ki = 0, kd = 0, out_lim = 0, int_lim = 0;
   longint err0 = 0, err1 = 0, err2 = 0, integ_acc = 0, drive_hold = 0;

   sample_pair_type   pending_samples[$];
   logic [TERM_W-1:0] drive_queue[$];
   logic [TERM_W-1:0] want_drive;

   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int hold_off_asked  = 0;
   int hold_off_served = 0;
   int hold_off_left   = 0;
   int quiet_cycles    = 0;
   int req_beats       = 0;
   int rsp_beats       = 0;
   int reg_writes      = 0;
   int mismatch_count  = 0;

   function automatic longint sat_q16(longint x);
      if (x > Q_MAX) return Q_MAX;
      if (x < Q_MIN) return Q_MIN;
      return x;
   endfunction

   function automatic longint limit_mag(longint x, longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
   endfunction

   // A write to a known register updates the shadow and wipes the loop state.
   function automatic void update_csr_model(logic [CSR_ADDR_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] value);
      bit known;
      known = 1'b1;
      case (idx)
         CSR_LOOP_MODE:      ctl_mode = loop_mode_type'(value[0]);
         CSR_GAIN_P:         kp = longint'($signed(value[GAIN_W-1:0]));
         CSR_GAIN_I:         ki = longint'($signed(value[GAIN_W-1:0]));
         CSR_GAIN_D:         kd = longint'($signed(value[GAIN_W-1:0]));
         CSR_OUT_LIMIT:      out_lim = longint'(value[LIMIT_W-1:0]);
         CSR_INTEGRAL_LIMIT: int_lim = longint'(value[LIMIT_W-1:0]);
         default:            known = 1'b0;
      endcase
      if (known) begin
         err0 = 0;
         err1 = 0;
         err2 = 0;
         integ_acc = 0;
         drive_hold = 0;
      end
   endfunction

   // Advances the shadow loop by one sample and returns the drive it produces.
   function automatic logic [TERM_W-1:0] next_drive(sample_pair_type s);
      longint p, i, d, y;
      err2 = err1;
      err1 = err0;
      err0 = longint'($signed(s.target)) - longint'($signed(s.measured));
      if (ctl_mode == MODE_POSITIONAL) begin
         p = sat_q16(kp * err0);
         integ_acc = limit_mag(sat_q16(integ_acc + sat_q16(ki * err0)), int_lim);
         d = sat_q16(kd * (err0 - err1));
         y = p + integ_acc + d;
      end else begin
         p = sat_q16(kp * (err0 - err1));
         i = sat_q16(ki * err0);
         integ_acc = i;
         d = sat_q16(kd * (err0 - 2 * err1 + err2));
         y = drive_hold + p + i + d;
      end
      drive_hold = limit_mag(y, out_lim);
      return drive_hold[TERM_W-1:0];
   endfunction

   // Sender: takes the next pending sample once the current beat has gone.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= pending_samples.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_off_asked != hold_off_served) begin
         hold_off_served = hold_off_served + 1;
         hold_off_left = HOLD_OFF_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predicts on every request beat and checks every drive beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            drive_queue.push_back(next_drive(sample_pair_type'(req_tdata)));
            req_beats++;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_beats++;
            if (drive_queue.size() == 0) begin
               mismatch_count++;
               $display("%0t: drive beat with nothing expected, expected none, got 0x%08h",
                        $time, rsp_tdata);
            end else begin
               want_drive = drive_queue.pop_front();
               if (rsp_tdata !== want_drive) begin
                  mismatch_count++;
                  $display("%0t: drive mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                           $time, $signed(want_drive), want_drive,
                           $signed(rsp_tdata), rsp_tdata);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Waits until no sample is waiting or in flight, then lets the block settle.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || drive_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      update_csr_model(idx, value);
      reg_writes++;
   endtask

   // Writes every register once; unused upper bits carry random junk.
   task automatic set_config(loop_mode_type mode, logic [GAIN_W-1:0] gp,
                             logic [GAIN_W-1:0] gi, logic [GAIN_W-1:0] gd,
                             logic [LIMIT_W-1:0] lo, logic [LIMIT_W-1:0] li);
      wait_idle();
      write_reg(CSR_LOOP_MODE, {30'($urandom()), mode});
      write_reg(CSR_GAIN_P, {7'($urandom()), gp});
      write_reg(CSR_GAIN_I, {7'($urandom()), gi});
      write_reg(CSR_GAIN_D, {7'($urandom()), gd});
      write_reg(CSR_OUT_LIMIT, lo);
      write_reg(CSR_INTEGRAL_LIMIT, li);
      @(negedge clock);
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(7))
         0:       return '0;
         1:       return GAIN_TOP;
         2:       return GAIN_BOTTOM;
         3, 4, 5: return 24'(int'($urandom_range(0, 262144)) - 131072);
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_limit();
      case ($urandom_range(5))
         0:       return '0;
         1:       return LIMIT_TOP;
         2, 3:    return 31'($urandom_range(0, 1 << 26));
         4:       return 31'($urandom_range(1, 65536 * 20));
         default: return 31'($urandom());
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2, 3:    return 16'(int'($urandom_range(0, 256)) - 128);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic void push_pair(int meas, int goal);
      sample_pair_type s;
      s.measured = 16'(meas);
      s.target   = 16'(goal);
      pending_samples.push_back(s);
   endfunction

   // Mostly runs that track a fixed setpoint, the rest unrelated noise.
   task automatic push_random(int n);
      int run_len;
      int meas;
      int goal;
      while (n > 0) begin
         if ($urandom_range(3) == 0) begin
            push_pair(pick_sample(), pick_sample());
            n--;
         end else begin
            goal = pick_sample();
            meas = pick_sample();
            run_len = $urandom_range(4, 24);
            while (run_len > 0 && n > 0) begin
               push_pair(meas, goal);
               n--;
               run_len--;
               meas = meas + (goal - meas) / 3 + int'($urandom_range(0, 16)) - 8;
               if (meas > 32767) meas = 32767;
               if (meas < -32768) meas = -32768;
            end
         end
      end
   endtask

   initial begin
      int phase;
      send_idle_pct = 12;
      recv_idle_pct = 47;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Moderate gains, integral limit small enough to be reached.
      set_config(MODE_POSITIONAL, GAIN_ONE, GAIN_QUARTER, GAIN_HALF,
                 LIMIT_TOP, 31'(200 * 65536));
      push_pair(0, 0);
      push_pair(-32768, 32767);
      push_pair(32767, -32768);
      push_pair(-1, 0);
      push_pair(0, -1);
      push_pair(100, 100);
      push_pair(0, 50);
      push_pair(0, 50);
      push_pair(0, 50);

      // Extreme gains: the large errors saturate the products.
      set_config(MODE_POSITIONAL, GAIN_TOP, GAIN_BOTTOM, GAIN_TOP,
                 31'(1000 * 65536), LIMIT_TOP);
      push_pair(-32768, 32767);
      push_pair(32767, -32768);
      push_pair(32767, -32768);
      push_pair(0, 1);
      push_pair(0, 0);

      // Incremental form, with a write to an unused index part way through.
      set_config(MODE_INCREMENTAL, GAIN_TWO, GAIN_HALF, 24'(-65536),
                 31'(3000 * 65536), '0);
      push_pair(0, 10);
      push_pair(0, 20);
      push_pair(5, 20);
      wait_idle();
      write_reg(CSR_SPARE_LO, 31'($urandom()));
      @(negedge clock);
      push_pair(-32768, 32767);
      push_pair(32767, -32768);
      push_pair(0, 0);

      // Both limits at zero force the integral and the drive to zero.
      set_config(MODE_POSITIONAL, GAIN_ONE, GAIN_ONE, GAIN_ONE, '0, '0);
      push_pair(1, 100);
      push_pair(0, -32768);
      push_pair(32767, 0);

      // Mostly random settings, the phases grouped into three stall patterns.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            1:       set_config(MODE_POSITIONAL, GAIN_TOP, GAIN_BOTTOM, GAIN_BOTTOM,
                                LIMIT_TOP, LIMIT_TOP);
            5:       set_config(MODE_INCREMENTAL, GAIN_BOTTOM, GAIN_TOP, GAIN_TOP,
                                LIMIT_TOP, LIMIT_TOP);
            default: set_config(loop_mode_type'($urandom_range(1)), pick_gain(),
                                pick_gain(), pick_gain(), pick_limit(), pick_limit());
         endcase
         if (phase < 4) begin
            send_idle_pct = 12;
            recv_idle_pct = 47;
         end else if (phase < 7) begin
            send_idle_pct = 47;
            recv_idle_pct = 12;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (phase == 2) begin
            // Sender pauses until every drive is back, then an ignored write.
            push_random(ITEMS_PER_PHASE / 2);
            wait_idle();
            write_reg(CSR_SPARE_HI, 31'($urandom()));
            @(negedge clock);
            push_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
         end else if (phase == 3 || phase == 8) begin
            // Long receiver hold-off while samples keep coming.
            push_random(ITEMS_PER_PHASE / 2);
            hold_off_asked = hold_off_asked + 1;
            push_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
         end else begin
            push_random(ITEMS_PER_PHASE);
         end
      end

      wait_idle();
      repeat (8) @(negedge clock);
      $display("Run covered %0d samples and %0d drive beats over %0d register writes,",
               req_beats, rsp_beats, reg_writes);
      $display("both loop forms, saturating gains, zero limits and long receiver stalls.");
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
